FILE: sv/chs_pkg.sv
package chs_pkg;

  localparam int KEY_W = 31;
  localparam int TS_W = 5;
  localparam int BUCKET_W = 4;
  localparam logic [TS_W-1:0] TS_RESET = 5'd16;

  // The hash unit retires DIV_BITS dividend bits per cycle.
  localparam int DIV_BITS = 4;
  localparam int HASH_CYCLES = (KEY_W + DIV_BITS - 1) / DIV_BITS;
  localparam int PAD_W = HASH_CYCLES * DIV_BITS;
  localparam int HASH_CNT_W = (HASH_CYCLES > 1) ? $clog2(HASH_CYCLES) : 1;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_SEARCH = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_DUP  = 2'd1,
    ST_MISS = 2'd2,
    ST_FULL = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_EVAL,
    S_PUSH
  } state_e;

  typedef struct packed {
    logic [1:0]       kind;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    status_e             status;
    logic [BUCKET_W-1:0] bucket;
  } out_item_t;

endpackage

FILE: sv/chs_hash.sv
module chs_hash (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [chs_pkg::KEY_W-1:0] key_i,
  input  logic [chs_pkg::TS_W-1:0]  divisor_i,
  output logic                      done_o,
  output logic [chs_pkg::TS_W-1:0]  bucket_o
);
  import chs_pkg::*;

  logic [PAD_W-1:0]      shift_q, shift_d;
  logic [TS_W-1:0]       div_q, div_d;
  logic [TS_W-1:0]       rem1_q, rem1_d;
  logic [TS_W-1:0]       rem2_q, rem2_d;
  logic [HASH_CNT_W-1:0] cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;

  // Two restoring remainder chains run side by side: the first divides the
  // key by the divisor, and each quotient bit it yields, most significant
  // first, feeds the second chain, which reduces the quotient by the same
  // divisor.
  always_comb begin
    logic [TS_W-1:0] r1;
    logic [TS_W-1:0] r2;
    logic [TS_W:0]   t1;
    logic [TS_W:0]   t2;
    logic [TS_W:0]   dv;
    logic            qb;
    r1 = rem1_q;
    r2 = rem2_q;
    dv = {1'b0, div_q};
    for (int i = 0; i < DIV_BITS; i++) begin
      t1 = {r1, shift_q[PAD_W-1-i]};
      if (t1 >= dv) begin
        qb = 1'b1;
        t1 = t1 - dv;
      end else begin
        qb = 1'b0;
      end
      r1 = t1[TS_W-1:0];
      t2 = {r2, qb};
      if (t2 >= dv) begin
        t2 = t2 - dv;
      end
      r2 = t2[TS_W-1:0];
    end

    shift_d = shift_q;
    div_d   = div_q;
    rem1_d  = rem1_q;
    rem2_d  = rem2_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      shift_d = PAD_W'(key_i);
      div_d   = divisor_i;
      rem1_d  = '0;
      rem2_d  = '0;
      cnt_d   = '0;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      shift_d = shift_q << DIV_BITS;
      rem1_d  = r1;
      rem2_d  = r2;
      cnt_d   = cnt_q + 1'b1;
      if (cnt_q == HASH_CNT_W'(HASH_CYCLES - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    div_q   <= div_d;
    rem1_q  <= rem1_d;
    rem2_q  <= rem2_d;
  end

  assign done_o   = done_q;
  assign bucket_o = rem2_q;

endmodule

FILE: sv/chained_hash_set.sv
// Channel   Direction  Handshake              Payload
// cfg       in         cfg_we_i               cfg_wdata_i  (table size, 5 bits)
// in        in         in_valid_i / in_stall_o in_i        (kind, key)
// out       out        out_valid_o / out_stall_i out_o     (status, bucket)
//
// One transaction is handled at a time, from acceptance to the result
// register. The hash unit retires four key bits per cycle, and its done
// flag is registered before the bucket row is read; then the row is
// compared, updated and written back, and the result is loaded into the
// output register, or waits in S_PUSH while the output stalls. The next
// transaction is taken once the block is back in S_IDLE.
// After reset the valid memory is swept clear, one row per cycle, so no
// transaction is accepted until the sweep has finished.
// A stalled result holds in the output register while the next transaction
// is accepted and hashed; only the final result hand-off waits for it.
module chained_hash_set #(
  parameter int BUCKETS          = 16,
  parameter int SLOTS_PER_BUCKET = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [chs_pkg::TS_W-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  chs_pkg::in_item_t        in_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output chs_pkg::out_item_t       out_o
);
  import chs_pkg::*;

  localparam int RowW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int KeyRowW = SLOTS_PER_BUCKET * KEY_W;
  // The table size can never exceed the bucket count nor the 5-bit field.
  localparam int TsCap   = (BUCKETS < 31) ? BUCKETS : 31;
  localparam logic [TS_W-1:0] TsCapW = TS_W'(TsCap);

  state_e state_q, state_d;

  logic [TS_W-1:0]     ts_q;
  logic [TS_W-1:0]     ts_eff;
  logic [1:0]          kind_q;
  logic [KEY_W-1:0]    key_q;
  logic [RowW-1:0]     row_q;
  logic [BUCKET_W-1:0] bucket_q;
  logic [RowW-1:0]     clr_q, clr_d;

  logic [KeyRowW-1:0]          key_mem [BUCKETS];
  logic [SLOTS_PER_BUCKET-1:0] vld_mem [BUCKETS];
  logic [KeyRowW-1:0]          key_rd_q;
  logic [SLOTS_PER_BUCKET-1:0] vld_rd_q;

  logic                        in_accept;
  logic                        hash_done;
  logic [TS_W-1:0]             hash_bucket;
  logic                        rd_en;
  logic                        key_we;
  logic                        vld_we;
  logic [RowW-1:0]             vld_waddr;
  logic [SLOTS_PER_BUCKET-1:0] vld_wdata;

  logic [SLOTS_PER_BUCKET-1:0] hit;
  logic [SLOTS_PER_BUCKET-1:0] hit_oh;
  logic [SLOTS_PER_BUCKET-1:0] free;
  logic [SLOTS_PER_BUCKET-1:0] free_oh;
  logic [KeyRowW-1:0]          key_row_new;
  logic [SLOTS_PER_BUCKET-1:0] vld_row_new;
  logic                        eval_key_we;
  logic                        eval_vld_we;
  status_e                     eval_status;

  logic      out_free;
  logic      out_load;
  out_item_t out_q, out_d;
  logic      out_valid_q, out_valid_d;
  out_item_t res_q, res_d;

  // A zero table size behaves as one bucket; sizes above the bucket count
  // saturate.
  always_comb begin
    if (ts_q == '0) begin
      ts_eff = TS_W'(1);
    end else if (ts_q > TsCapW) begin
      ts_eff = TsCapW;
    end else begin
      ts_eff = ts_q;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  chs_hash u_hash (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_accept),
    .key_i     (in_i.key),
    .divisor_i (ts_eff),
    .done_o    (hash_done),
    .bucket_o  (hash_bucket)
  );

  // Compare every slot of the bucket row at once, then pick the lowest
  // matching slot and the lowest empty slot as one-hot masks.
  always_comb begin
    for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
      hit[s] = vld_rd_q[s] && (key_rd_q[s*KEY_W +: KEY_W] == key_q);
    end
    free    = ~vld_rd_q;
    hit_oh  = hit & (~hit + 1'b1);
    free_oh = free & (~free + 1'b1);

    key_row_new = key_rd_q;
    for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
      if (free_oh[s]) begin
        key_row_new[s*KEY_W +: KEY_W] = key_q;
      end
    end

    eval_key_we = 1'b0;
    eval_vld_we = 1'b0;
    vld_row_new = vld_rd_q;
    case (kind_q)
      KIND_INSERT: begin
        if (|hit) begin
          eval_status = ST_DUP;
        end else if (!(|free)) begin
          eval_status = ST_FULL;
        end else begin
          eval_status = ST_DONE;
          eval_key_we = 1'b1;
          eval_vld_we = 1'b1;
          vld_row_new = vld_rd_q | free_oh;
        end
      end
      KIND_DELETE: begin
        if (|hit) begin
          eval_status = ST_DONE;
          eval_vld_we = 1'b1;
          vld_row_new = vld_rd_q & ~hit_oh;
        end else begin
          eval_status = ST_MISS;
        end
      end
      // Search, and the unused fourth code, only look.
      default: begin
        eval_status = (|hit) ? ST_DONE : ST_MISS;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    rd_en       = 1'b0;
    key_we      = 1'b0;
    vld_we      = 1'b0;
    vld_waddr   = row_q;
    vld_wdata   = vld_row_new;
    out_load    = 1'b0;
    out_d       = out_q;
    res_d       = res_q;
    unique case (state_q)
      S_CLEAR: begin
        vld_we    = 1'b1;
        vld_waddr = clr_q;
        vld_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == RowW'(BUCKETS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        rd_en   = 1'b1;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        key_we = eval_key_we;
        vld_we = eval_vld_we;
        res_d.status = eval_status;
        res_d.bucket = bucket_q;
        if (out_free) begin
          out_load = 1'b1;
          out_d    = res_d;
          state_d  = S_IDLE;
        end else begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          out_load = 1'b1;
          out_d    = res_q;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      ts_q        <= TS_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        ts_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q <= in_i.kind;
      key_q  <= in_i.key;
    end
    if (hash_done) begin
      row_q    <= RowW'(hash_bucket);
      bucket_q <= hash_bucket[BUCKET_W-1:0];
    end
    out_q <= out_d;
    res_q <= res_d;
  end

  // Key memory: one row of slots per bucket.
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[row_q] <= key_row_new;
    end
    if (rd_en) begin
      key_rd_q <= key_mem[row_q];
    end
  end

  // Slot valid memory, swept clear after reset.
  always_ff @(posedge clk_i) begin
    if (vld_we) begin
      vld_mem[vld_waddr] <= vld_wdata;
    end
    if (rd_en) begin
      vld_rd_q <= vld_mem[row_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
